@@ src/assert_macros.svh @@
// assertion macros for the pool allocator rtl
// clocked on i_clk, disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define FBPA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define FBPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/fbpa_pkg.sv @@
// types and constants of the fixed block pool allocator
// no dependencies
package fbpa_pkg;

    // field widths
    localparam int IDX_W   = 8;
    localparam int BYTES_W = 13;
    localparam int REQ_W   = 16;
    localparam int CNT_W   = 9;
    localparam int OFF_W   = 20;
    localparam int LINK_W  = IDX_W + 1;
    localparam int ACT_W   = 2;

    // largest pool the index field can address
    localparam int IDX_SPACE       = 1 << IDX_W;
    localparam int MAX_BLOCKS_DEF  = 256;

    // shift-add multiplier runs one multiplier bit per step
    localparam int MUL_STEPS = IDX_W;
    localparam int STEP_W    = $clog2(MUL_STEPS);

    // action codes
    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REBUILD = 2'd2;

    // configuration register indexes
    localparam logic CFG_BLOCK_BYTES   = 1'b0;
    localparam logic CFG_BLOCKS_IN_USE = 1'b1;

    // configuration reset values
    localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST   = 13'd64;
    localparam logic [CNT_W-1:0]   BLOCKS_IN_USE_RST = 9'd256;

    // request to the multiplier
    typedef struct packed {
        logic               start;
        logic [BYTES_W-1:0] mcand;
        logic [IDX_W-1:0]   mplier;
    } t_mul_req;

    // response from the multiplier
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [OFF_W-1:0] product;
    } t_mul_rsp;

endpackage

@@ src/fixed_block_pool_allocator_unit.sv @@
// allocate: link read and pop, then the shift-add multiply steps, then the result
// free and unused codes: straight to the result; rebuild: one link write per effective pool block
// one item at a time; input is ready only in idle, after the result moves to the output register
// a result waiting in the output register does not block the next input transfer
// synchronous active-low reset: list empty, block_bytes 64, blocks_in_use 256
// no clearing pass; link entries are valid only once written
module fixed_block_pool_allocator_unit
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [ACT_W-1:0]   i_action,
    input  logic [REQ_W-1:0]   i_request_bytes,
    input  logic [IDX_W-1:0]   i_release_index,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_granted,
    output logic [IDX_W-1:0]   o_block_index,
    output logic [OFF_W-1:0]   o_block_offset,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [BYTES_W-1:0] i_cfg_data
);

`include "assert_macros.svh"

    localparam int DEPTH = (MAX_BLOCKS < IDX_SPACE) ? MAX_BLOCKS : IDX_SPACE;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_POP     = 5'b00010,
        S_MUL     = 5'b00100,
        S_REBUILD = 5'b01000,
        S_DONE    = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [BYTES_W-1:0] r_block_bytes;
    logic [CNT_W-1:0]   r_blocks_in_use;
    logic               r_head_valid, n_head_valid;
    logic [IDX_W-1:0]   r_head_index, n_head_index;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_res_granted, n_res_granted;
    logic [IDX_W-1:0]   r_res_index, n_res_index;
    logic [OFF_W-1:0]   r_res_offset, n_res_offset;
    logic               r_out_valid;
    logic               r_out_granted;
    logic [IDX_W-1:0]   r_out_index;
    logic [OFF_W-1:0]   r_out_offset;

    logic [LINK_W-1:0]  r_link_mem [DEPTH];
    logic [LINK_W-1:0]  r_rd;
    logic               w_we;
    logic [AW-1:0]      w_wa;
    logic [LINK_W-1:0]  w_wd;
    logic [AW-1:0]      w_ra;

    logic               w_in_xfer;
    logic [CNT_W-1:0]   w_usable;
    logic               w_grant;
    logic [LINK_W-1:0]  w_head_link;
    logic [LINK_W-1:0]  w_pop_link;
    logic [CNT_W-1:0]   w_prev;
    logic               w_rebuild_last;
    logic               w_out_free;
    t_mul_req           w_mul_req;
    t_mul_rsp           w_mul_rsp;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // effective pool size
    assign w_usable = (r_blocks_in_use > DEPTH_CNT) ? DEPTH_CNT : r_blocks_in_use;

    // allocate qualification
    assign w_grant = (i_request_bytes != '0) && r_head_valid
                  && (i_request_bytes <= REQ_W'(r_block_bytes));

    // link value that points at the current head
    assign w_head_link = r_head_valid ? {1'b1, r_head_index} : '0;
    assign w_pop_link  = ({1'b0, r_head_index} < DEPTH_CNT) ? r_rd : '0;

    assign w_prev         = r_cnt - CNT_W'(1);
    assign w_rebuild_last = (r_cnt == w_usable - CNT_W'(1));

    // link memory port selection
    always_comb begin
        w_ra = r_head_index[AW-1:0];
        w_we = 1'b0;
        w_wa = i_release_index[AW-1:0];
        w_wd = w_head_link;
        if (r_state == S_REBUILD) begin
            w_we = 1'b1;
            w_wa = r_cnt[AW-1:0];
            w_wd = (r_cnt == '0) ? '0 : {1'b1, w_prev[IDX_W-1:0]};
        end else if (w_in_xfer && (i_action == ACT_FREE)
                     && ({1'b0, i_release_index} < w_usable)) begin
            w_we = 1'b1;
        end
    end

    // link memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_link_mem[w_wa] <= w_wd;
        end
        r_rd <= r_link_mem[w_ra];
    end

    // multiplier request
    assign w_mul_req.start  = (r_state == S_POP);
    assign w_mul_req.mcand  = r_block_bytes;
    assign w_mul_req.mplier = r_res_index;

    fbpa_shift_add_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_head_valid  = r_head_valid;
        n_head_index  = r_head_index;
        n_cnt         = r_cnt;
        n_res_granted = r_res_granted;
        n_res_index   = r_res_index;
        n_res_offset  = r_res_offset;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_res_granted = 1'b0;
                    n_res_index   = '0;
                    n_res_offset  = '0;
                    n_state       = S_DONE;
                    case (i_action)
                        ACT_ALLOC: begin
                            if (w_grant) begin
                                n_res_granted = 1'b1;
                                n_res_index   = r_head_index;
                                n_state       = S_POP;
                            end
                        end
                        ACT_FREE: begin
                            if ({1'b0, i_release_index} < w_usable) begin
                                n_head_index = i_release_index;
                                n_head_valid = 1'b1;
                            end
                        end
                        ACT_REBUILD: begin
                            n_head_valid = 1'b0;
                            n_head_index = '0;
                            n_cnt        = '0;
                            if (w_usable != '0) begin
                                n_state = S_REBUILD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                if (w_pop_link[IDX_W]) begin
                    n_head_index = w_pop_link[IDX_W-1:0];
                end else begin
                    n_head_valid = 1'b0;
                    n_head_index = '0;
                end
                n_state = S_MUL;
            end
            S_MUL: begin
                if (w_mul_rsp.done) begin
                    n_res_offset = w_mul_rsp.product;
                    n_state      = S_DONE;
                end
            end
            S_REBUILD: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (w_rebuild_last) begin
                    n_head_valid = 1'b1;
                    n_head_index = r_cnt[IDX_W-1:0];
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_head_valid    <= 1'b0;
            r_head_index    <= '0;
            r_cnt           <= '0;
            r_block_bytes   <= BLOCK_BYTES_RST;
            r_blocks_in_use <= BLOCKS_IN_USE_RST;
            r_out_valid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head_valid <= n_head_valid;
            r_head_index <= n_head_index;
            r_cnt        <= n_cnt;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BLOCK_BYTES:   r_block_bytes   <= i_cfg_data;
                    CFG_BLOCKS_IN_USE: r_blocks_in_use <= i_cfg_data[CNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_res_granted <= n_res_granted;
        r_res_index   <= n_res_index;
        r_res_offset  <= n_res_offset;
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_granted <= r_res_granted;
            r_out_index   <= r_res_index;
            r_out_offset  <= r_res_offset;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_granted      = r_out_granted;
    assign o_block_index  = r_out_index;
    assign o_block_offset = r_out_offset;

    // checks
    `FBPA_ASSERT_NEXT(a_deny_direct, w_in_xfer && (i_action == ACT_ALLOC) && !w_grant, (r_state == S_DONE) && !r_res_granted, "denied allocate did not go straight to result")
    `FBPA_ASSERT_ALWAYS(a_mul_done_in_mul, !w_mul_rsp.done || (r_state == S_MUL), "multiplier finished outside multiply state")
    `FBPA_ASSERT_NEXT(a_rebuild_head, (r_state == S_REBUILD) && w_rebuild_last, r_head_valid && (r_head_index == $past(r_cnt[IDX_W-1:0])), "rebuild left wrong head")
    `FBPA_ASSERT_ALWAYS(a_mul_idle_outside, w_mul_rsp.busy || (r_state != S_MUL) || w_mul_rsp.done || $past(r_state == S_POP), "multiply state without a running multiplier")

endmodule

@@ src/fbpa_shift_add_mul.sv @@
// iterative shift-add multiplier for the block byte offset
// depends on fbpa_pkg; product is taken modulo 2^OFF_W
module fbpa_shift_add_mul
    import fbpa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic [OFF_W-1:0]  r_acc,    n_acc;
    logic [OFF_W-1:0]  r_mcand,  n_mcand;
    logic [IDX_W-1:0]  r_mplier, n_mplier;
    logic [STEP_W-1:0] r_step,   n_step;
    logic              r_busy,   n_busy;
    logic              r_done,   n_done;

    // one add of the shifted multiplicand per step
    always_comb begin
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_step   = r_step;
        n_busy   = r_busy;
        n_done   = 1'b0;
        if (i_req.start && !r_busy) begin
            n_acc    = '0;
            n_mcand  = OFF_W'(i_req.mcand);
            n_mplier = i_req.mplier;
            n_step   = '0;
            n_busy   = 1'b1;
        end else if (r_busy) begin
            n_acc    = r_acc + (r_mplier[0] ? r_mcand : '0);
            n_mcand  = {r_mcand[OFF_W-2:0], 1'b0};
            n_mplier = {1'b0, r_mplier[IDX_W-1:1]};
            n_step   = r_step + STEP_W'(1);
            if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

    assign o_rsp.busy    = r_busy;
    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule

@@ test/fixed_block_pool_allocator_unit_tb.sv @@
// self-checking testbench for the fixed block pool allocator: directed and random
// alloc/free/rebuild traffic with a free-list predictor; depends on fbpa_pkg and the unit
module fixed_block_pool_allocator_unit_tb;
    import fbpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_ITEMS   = 210;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [REQ_W-1:0] request_bytes;
        logic [IDX_W-1:0] release_index;
    } t_pool_req;

    typedef struct packed {
        logic             granted;
        logic [IDX_W-1:0] block_index;
        logic [OFF_W-1:0] block_offset;
    } t_grant;

    // block inputs, all known from time zero
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic [ACT_W-1:0]   i_action = '0;
    logic [REQ_W-1:0]   i_request_bytes = '0;
    logic [IDX_W-1:0]   i_release_index = '0;
    logic               i_out_ready = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               i_cfg_index = CFG_BLOCK_BYTES;
    logic [BYTES_W-1:0] i_cfg_data = '0;

    logic               o_in_ready;
    logic               o_out_valid;
    logic               o_granted;
    logic [IDX_W-1:0]   o_block_index;
    logic [OFF_W-1:0]   o_block_offset;
    logic               o_cfg_ready;

    fixed_block_pool_allocator_unit #(
        .MAX_BLOCKS(MAX_BLOCKS_DEF)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_request_bytes (i_request_bytes),
        .i_release_index (i_release_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_granted       (o_granted),
        .o_block_index   (o_block_index),
        .o_block_offset  (o_block_offset),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // free-list mirror and configuration copy
    logic               pool_head_valid = 1'b0;
    logic [IDX_W-1:0]   pool_head_idx = '0;
    logic [LINK_W-1:0]  pool_link [IDX_SPACE];
    logic [BYTES_W-1:0] cfg_block_bytes = BLOCK_BYTES_RST;
    logic [CNT_W-1:0]   cfg_pool_count = BLOCKS_IN_USE_RST;

    t_pool_req pending_q [$];
    t_grant    grant_q [$];
    t_pool_req in_flight;
    int        err_count = 0;
    int        cycle_count = 0;
    int        send_pause = 0;
    int        recv_pause = 0;
    int        queued_count = 0;
    int        answered_count = 0;
    bit        steady = 1'b0;

    // clock
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want,
                 cycle_count);
        err_count++;
    endtask

    // blocks the pool may hold under the current count
    function automatic int pool_limit();
        int n;
        n = int'(cfg_pool_count);
        if (n > MAX_BLOCKS_DEF)
            n = MAX_BLOCKS_DEF;
        if (n > IDX_SPACE)
            n = IDX_SPACE;
        return n;
    endfunction

    function automatic void push_free_block(input logic [IDX_W-1:0] idx);
        pool_link[idx] = pool_head_valid ? {1'b1, pool_head_idx} : '0;
        pool_head_idx = idx;
        pool_head_valid = 1'b1;
    endfunction

    // expected grant for one accepted request, updating the free-list mirror
    function automatic t_grant predict_grant(input t_pool_req req);
        t_grant            g;
        logic [LINK_W-1:0] lk;
        int                prod;
        int                n;
        g = '0;
        case (req.action)
            ACT_ALLOC: begin
                if (req.request_bytes != '0 &&
                    int'(req.request_bytes) <= int'(cfg_block_bytes) && pool_head_valid) begin
                    lk = pool_link[pool_head_idx];
                    prod = int'(pool_head_idx) * int'(cfg_block_bytes);
                    g.granted = 1'b1;
                    g.block_index = pool_head_idx;
                    g.block_offset = prod[OFF_W-1:0];
                    if (lk[IDX_W]) begin
                        pool_head_idx = lk[IDX_W-1:0];
                    end else begin
                        pool_head_valid = 1'b0;
                        pool_head_idx = '0;
                    end
                end
            end
            ACT_FREE: begin
                if (int'(req.release_index) < pool_limit())
                    push_free_block(req.release_index);
            end
            ACT_REBUILD: begin
                n = pool_limit();
                pool_head_valid = 1'b0;
                pool_head_idx = '0;
                for (int i = 0; i < n; i++)
                    push_free_block(IDX_W'(i));
            end
            default: ;
        endcase
        return g;
    endfunction

    // gap length: mostly none or short, now and then long
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                grant_q.push_back(predict_grant(in_flight));
            if (!i_in_valid || o_in_ready) begin
                if (send_pause > 0) begin
                    send_pause--;
                    i_in_valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    in_flight = pending_q.pop_front();
                    i_action <= in_flight.action;
                    i_request_bytes <= in_flight.request_bytes;
                    i_release_index <= in_flight.release_index;
                    i_in_valid <= 1'b1;
                    send_pause = pick_pause();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (grant_q.size() == 0) begin
                    report_mismatch("unexpected result, index", 32'(o_block_index), 32'd0);
                end else begin
                    want = grant_q.pop_front();
                    answered_count++;
                    if (o_granted !== want.granted)
                        report_mismatch("granted", 32'(o_granted), 32'(want.granted));
                    if (o_block_index !== want.block_index)
                        report_mismatch("block_index", 32'(o_block_index),
                                        32'(want.block_index));
                    if (o_block_offset !== want.block_offset)
                        report_mismatch("block_offset", 32'(o_block_offset),
                                        32'(want.block_offset));
                end
            end
            if (recv_pause > 0) begin
                recv_pause--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                recv_pause = pick_pause();
            end
        end
    end

    function automatic void add_req(input logic [ACT_W-1:0] act, input int req, input int rel);
        t_pool_req r;
        r.action = act;
        r.request_bytes = REQ_W'(req);
        r.release_index = IDX_W'(rel);
        pending_q.push_back(r);
        queued_count++;
    endfunction

    // wait until every request has been answered and the unit has gone quiet
    task automatic settle();
        do
            @(posedge i_clk);
        while (answered_count != queued_count);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input int val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= BYTES_W'(val);
        forever begin
            @(posedge i_clk);
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_BLOCK_BYTES)
                    cfg_block_bytes = i_cfg_data;
                else
                    cfg_pool_count = i_cfg_data[CNT_W-1:0];
                i_cfg_valid <= 1'b0;
                break;
            end
        end
    endtask

    task automatic set_pool(input int bytes, input int count);
        settle();
        write_register(CFG_BLOCK_BYTES, bytes);
        write_register(CFG_BLOCKS_IN_USE, count);
    endtask

    // allocate size: mostly fitting, sometimes zero or oversized
    function automatic int rand_request();
        int r;
        int top;
        r = $urandom_range(0, 99);
        top = (cfg_block_bytes == '0) ? 1 : int'(cfg_block_bytes);
        if (r < 82)
            return $urandom_range(1, top);
        if (r < 88)
            return 0;
        if (r < 94)
            return $urandom_range(top + 1, 65535);
        return $urandom_range(0, 65535);
    endfunction

    // free index: mostly inside the pool, sometimes anywhere
    function automatic int rand_release();
        int n;
        n = pool_limit();
        if (n > 0 && $urandom_range(0, 99) < 85)
            return $urandom_range(0, n - 1);
        return $urandom_range(0, 255);
    endfunction

    task automatic random_phase(input int bytes, input int count, input bit rebuild_first);
        int r;
        set_pool(bytes, count);
        if (rebuild_first)
            add_req(ACT_REBUILD, $urandom_range(0, 65535), $urandom_range(0, 255));
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                add_req(ACT_ALLOC, rand_request(), $urandom_range(0, 255));
            else if (r < 90)
                add_req(ACT_FREE, $urandom_range(0, 65535), rand_release());
            else if (r < 95)
                add_req(ACT_REBUILD, $urandom_range(0, 65535), $urandom_range(0, 255));
            else
                add_req(ACT_UNUSED, $urandom_range(0, 65535), $urandom_range(0, 255));
        end
    endtask

    // stimulus sequence
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: empty list, then a full rebuild
        add_req(ACT_ALLOC, 1, 0);
        add_req(ACT_FREE, 0, 0);
        add_req(ACT_ALLOC, 64, 0);
        add_req(ACT_REBUILD, 0, 0);
        add_req(ACT_ALLOC, 0, 0);
        add_req(ACT_ALLOC, 65, 0);
        add_req(ACT_ALLOC, 16'hFFFF, 8'hFF);
        add_req(ACT_ALLOC, 64, 0);
        add_req(ACT_ALLOC, 1, 0);
        add_req(ACT_FREE, 0, 255);
        add_req(ACT_FREE, 0, 254);
        add_req(ACT_FREE, 0, 254);
        add_req(ACT_UNUSED, 16'hFFFF, 8'hFF);
        add_req(ACT_FREE, 16'hFFFF, 0);
        add_req(ACT_ALLOC, 1, 8'hFF);
        add_req(ACT_ALLOC, 1, 0);

        // largest block size, oversized count, offset wrap
        set_pool(8191, 511);
        add_req(ACT_REBUILD, 0, 0);
        add_req(ACT_ALLOC, 8191, 0);
        add_req(ACT_ALLOC, 8192, 0);

        // zero block size denies everything
        set_pool(0, 511);
        add_req(ACT_ALLOC, 1, 0);

        // empty pool
        set_pool(8, 0);
        add_req(ACT_REBUILD, 0, 0);
        add_req(ACT_FREE, 0, 0);
        add_req(ACT_ALLOC, 8, 0);

        // count shrunk after a rebuild keeps the list
        set_pool(8, 256);
        add_req(ACT_REBUILD, 0, 0);
        set_pool(8, 3);
        add_req(ACT_FREE, 0, 200);
        add_req(ACT_FREE, 0, 2);
        add_req(ACT_ALLOC, 8, 0);
        add_req(ACT_ALLOC, 8, 0);

        // random traffic over several pool settings
        random_phase(8, 2, 1'b1);
        random_phase(4096, 256, 1'b1);
        random_phase(8191, 511, 1'b1);
        steady = 1'b1;
        random_phase(13, 1, 1'b1);
        steady = 1'b0;
        random_phase($urandom_range(8, 4096), $urandom_range(0, 64), 1'b0);
        random_phase($urandom_range(1, 8191), $urandom_range(257, 511), 1'b1);
        steady = 1'b1;
        random_phase($urandom_range(8, 4096), $urandom_range(3, 40), 1'b1);
        steady = 1'b0;
        random_phase($urandom_range(8, 8191), $urandom_range(0, 256), 1'b1);

        settle();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
